// File: hdl/grpr_pkg.sv
// Shared types, constants and parameter defaults for the glyph row pixel rasterizer.
`default_nettype none

package grpr_pkg;

   localparam int CELL_WIDTH_DEF  = 6;
   localparam int MAX_MAGNIFY_DEF = 2;

   localparam int COLOUR_W = 16;
   localparam int GLYPH_W  = 8;
   localparam int ROW_W    = 4;
   localparam int SCALE_W  = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_SCALE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GLOBAL_REVERSE = 1'd1;

   localparam logic [GLYPH_W-1:0] BAR_BITS      = 8'hFC;
   localparam logic [ROW_W-1:0]   UNDERLINE_ROW = 4'd11;
   localparam logic [ROW_W-1:0]   STRIKE_ROW    = 4'd6;

   typedef struct packed {
      logic [SCALE_W-1:0] pixel_scale;
      logic               global_reverse;
   } cfg_type;

   // Resolved cell row: final colours, glyph bits with pix[i] for column i.
   typedef struct packed {
      logic [COLOUR_W-1:0] fore;
      logic [COLOUR_W-1:0] back;
      logic [GLYPH_W-1:0]  pix;
      logic [SCALE_W-1:0]  scale_m1;
   } item_type;

endpackage

`default_nettype wire

// File: hdl/grpr_channels.sv
// Valid/ready channel interfaces for cell row requests and pixel responses.
`default_nettype none

interface grpr_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] fore_colour;
   logic [15:0] back_colour;
   logic        dim_flag;
   logic        invisible_flag;
   logic        reverse_flag;
   logic        cursor_here;
   logic        wide_tail_flag;
   logic        underline_flag;
   logic        strike_flag;
   logic [7:0]  glyph_bits;
   logic [3:0]  glyph_row;

   modport source (
      output valid, fore_colour, back_colour, dim_flag, invisible_flag, reverse_flag,
             cursor_here, wide_tail_flag, underline_flag, strike_flag, glyph_bits, glyph_row,
      input  ready
   );
   modport sink (
      input  valid, fore_colour, back_colour, dim_flag, invisible_flag, reverse_flag,
             cursor_here, wide_tail_flag, underline_flag, strike_flag, glyph_bits, glyph_row,
      output ready
   );
endinterface

interface grpr_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_colour;
   logic        last_pixel;

   modport source (output valid, pixel_colour, last_pixel, input ready);
   modport sink   (input valid, pixel_colour, last_pixel, output ready);
endinterface

`default_nettype wire

// File: hdl/grpr_resolve.sv
// Input stage: resolves colours and glyph bits of one cell row into a holding slot.
`default_nettype none

module grpr_resolve #(
   parameter int MAX_MAGNIFY = grpr_pkg::MAX_MAGNIFY_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire grpr_pkg::cfg_type cfg,
   grpr_req_if.sink               req,
   input  wire logic              take,
   output grpr_pkg::item_type     slot,
   output logic                   slot_valid
);

   function automatic logic [15:0] halve_swapped(input logic [15:0] c);
      logic [15:0] v;
      logic [15:0] h;
      v = {c[7:0], c[15:8]};
      h = {1'b0, v[15:12], 1'b0, v[10:6], 1'b0, v[4:1]};
      return {h[7:0], h[15:8]};
   endfunction

   logic                    slot_valid_ff, slot_valid_in;
   grpr_pkg::item_type      slot_ff, resolved;
   logic [15:0]             fore_dim, fore_vis;
   logic                    swap;
   logic [7:0]              bits;
   logic [grpr_pkg::SCALE_W-1:0] scale_m1;
   logic                    accept;

   assign req.ready  = !slot_valid_ff || take;
   assign accept     = req.valid && req.ready;
   assign slot       = slot_ff;
   assign slot_valid = slot_valid_ff;

   always_comb begin
      fore_dim = req.dim_flag ? halve_swapped(req.fore_colour) : req.fore_colour;
      fore_vis = req.invisible_flag ? req.back_colour : fore_dim;
      swap     = req.reverse_flag ^ cfg.global_reverse ^ req.cursor_here;

      bits = req.wide_tail_flag ? '0 : req.glyph_bits;
      if (req.underline_flag && (req.glyph_row == grpr_pkg::UNDERLINE_ROW)) begin
         bits = grpr_pkg::BAR_BITS;
      end
      if (req.strike_flag && (req.glyph_row == grpr_pkg::STRIKE_ROW)) begin
         bits = grpr_pkg::BAR_BITS;
      end

      // Clamp scale into 1..MAX_MAGNIFY, kept as scale minus one.
      if (cfg.pixel_scale == '0) begin
         scale_m1 = '0;
      end else if (int'(cfg.pixel_scale) > MAX_MAGNIFY) begin
         scale_m1 = grpr_pkg::SCALE_W'(MAX_MAGNIFY - 1);
      end else begin
         scale_m1 = cfg.pixel_scale - grpr_pkg::SCALE_W'(1);
      end

      resolved.fore     = swap ? req.back_colour : fore_vis;
      resolved.back     = swap ? fore_vis : req.back_colour;
      resolved.scale_m1 = scale_m1;
      // Column i reads glyph bit 7-i, so bit-reverse once here.
      for (int i = 0; i < grpr_pkg::GLYPH_W; i++) begin
         resolved.pix[i] = bits[grpr_pkg::GLYPH_W-1-i];
      end
   end

   always_comb begin
      slot_valid_in = slot_valid_ff;
      if (accept) begin
         slot_valid_in = 1'b1;
      end else if (take) begin
         slot_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff <= resolved;
      end
   end

endmodule

`default_nettype wire

// File: hdl/grpr_emit.sv
// Pixel sequencer: walks columns and replicas of a resolved row into the output register.
`default_nettype none

module grpr_emit #(
   parameter int CELL_WIDTH  = grpr_pkg::CELL_WIDTH_DEF,
   parameter int MAX_MAGNIFY = grpr_pkg::MAX_MAGNIFY_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire grpr_pkg::item_type   slot,
   input  wire logic                 slot_valid,
   output logic                      take,
   grpr_rsp_if.source                rsp
);

   localparam int GX_W  = (CELL_WIDTH > 1) ? $clog2(CELL_WIDTH) : 1;
   localparam int CNT_W = (MAX_MAGNIFY > 1) ? $clog2(MAX_MAGNIFY) : 1;

   grpr_pkg::item_type item_ff, item_in;
   logic               busy_ff, busy_in;
   logic [GX_W-1:0]    gx_ff, gx_in;
   logic [CNT_W-1:0]   sx_ff, sx_in;
   logic [CNT_W-1:0]   sy_ff, sy_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        pixel_ff, pixel_in;
   logic               last_ff, last_in;
   logic               advance;
   logic               sx_end, gx_end, sy_end, at_last;
   logic [2:0]         col;

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.pixel_colour = pixel_ff;
   assign rsp.last_pixel   = last_ff;

   always_comb begin
      advance = busy_ff && (!rsp_valid_ff || rsp.ready);
      sx_end  = (sx_ff == item_ff.scale_m1[CNT_W-1:0]);
      sy_end  = (sy_ff == item_ff.scale_m1[CNT_W-1:0]);
      gx_end  = (gx_ff == GX_W'(CELL_WIDTH - 1));
      at_last = sx_end && gx_end && sy_end;
      take    = slot_valid && (!busy_ff || (advance && at_last));
      col     = 3'(gx_ff);

      item_in      = item_ff;
      busy_in      = busy_ff;
      gx_in        = gx_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      rsp_valid_in = rsp_valid_ff;
      pixel_in     = pixel_ff;
      last_in      = last_ff;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
         pixel_in     = item_ff.pix[col] ? item_ff.fore : item_ff.back;
         last_in      = at_last;
         // Step replica, then column, then line repeat.
         if (sx_end) begin
            sx_in = '0;
            if (gx_end) begin
               gx_in = '0;
               sy_in = sy_ff + CNT_W'(1);
            end else begin
               gx_in = gx_ff + GX_W'(1);
            end
         end else begin
            sx_in = sx_ff + CNT_W'(1);
         end
         if (at_last) begin
            busy_in = 1'b0;
         end
      end

      if (take) begin
         busy_in = 1'b1;
         item_in = slot;
         gx_in   = '0;
         sx_in   = '0;
         sy_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gx_ff        <= '0;
         sx_ff        <= '0;
         sy_ff        <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         gx_ff        <= gx_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      pixel_ff <= pixel_in;
      last_ff  <= last_in;
   end

endmodule

`default_nettype wire

// File: hdl/glyph_row_pixel_rasterizer.sv
// Top level of the glyph row pixel rasterizer: control registers and the two stages.
//
//   channel | direction | handshake        | moves
//   req_if  | in        | valid/ready      | one cell row item
//   rsp_if  | out       | valid/ready      | one pixel item, last_pixel on the final one
//   csr_*   | in        | csr_we, no ready | pixel_scale, global_reverse
//
// Each row item yields CELL_WIDTH * s * s pixels, one per cycle while rsp_if is ready,
// from the output register, s being the clamped scale: 6 pixels at scale 1, 24 at scale 2.
// The first pixel is registered in the slot, the item register and the output register;
// a held slot takes the next item while the sequencer works, so rows follow with no gap.
// A stalled rsp_if holds the pixel; reset (synchronous) sets scale 1 and reverse off.
`default_nettype none

module glyph_row_pixel_rasterizer #(
   parameter int CELL_WIDTH  = grpr_pkg::CELL_WIDTH_DEF,
   parameter int MAX_MAGNIFY = grpr_pkg::MAX_MAGNIFY_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   grpr_req_if.sink                             req_if,
   grpr_rsp_if.source                           rsp_if,
   input  wire logic                            csr_we,
   input  wire logic [grpr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [grpr_pkg::CSR_DATA_W-1:0] csr_wdata
);

   grpr_pkg::cfg_type  cfg_ff, cfg_in;
   grpr_pkg::item_type slot;
   logic               slot_valid;
   logic               take;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            grpr_pkg::CSR_PIXEL_SCALE: begin
               cfg_in.pixel_scale = csr_wdata[grpr_pkg::SCALE_W-1:0];
            end
            grpr_pkg::CSR_GLOBAL_REVERSE: begin
               cfg_in.global_reverse = csr_wdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_scale    <= grpr_pkg::SCALE_W'(1);
         cfg_ff.global_reverse <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   grpr_resolve #(
      .MAX_MAGNIFY (MAX_MAGNIFY)
   ) u_resolve (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req_if),
      .take       (take),
      .slot       (slot),
      .slot_valid (slot_valid)
   );

   grpr_emit #(
      .CELL_WIDTH  (CELL_WIDTH),
      .MAX_MAGNIFY (MAX_MAGNIFY)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .slot       (slot),
      .slot_valid (slot_valid),
      .take       (take),
      .rsp        (rsp_if)
   );

endmodule

`default_nettype wire

// File: hdl/grpr_checker.sv
// Port-level checks for the glyph row pixel rasterizer, bound to the top level.
`default_nettype none

module grpr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_pixel,
   input wire logic        rsp_last
);

   // Rows accepted whose last pixel has not yet been taken.
   logic [2:0] open_ff, open_in;
   logic       req_fire, done_fire;

   assign req_fire  = req_valid && req_ready;
   assign done_fire = rsp_valid && rsp_ready && rsp_last;

   always_comb begin
      open_in = open_ff + 3'(req_fire) - 3'(done_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel) && $stable(rsp_last))
      else $error("pixel dropped or changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("pixel shown right after reset");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 3'd0)
      else $error("pixel without an open row");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      open_ff <= 3'd3)
      else $error("more rows in flight than the stages can hold");

endmodule

bind glyph_row_pixel_rasterizer grpr_checker u_grpr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_pixel (rsp_if.pixel_colour),
   .rsp_last  (rsp_if.last_pixel)
);

`default_nettype wire

// File: tb/sv/glyph_row_pixel_rasterizer_tb.sv
// Self-checking testbench for the glyph row pixel rasterizer: random and directed cell rows.
`timescale 1ns / 1ps

module glyph_row_pixel_rasterizer_tb;

   localparam int HALF_PERIOD = 4;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 300;
   localparam int TAIL_CYCLES = 20;

   // attribute masks, in the order {dim, invisible, reverse, cursor, wide tail, underline, strike}
   localparam logic [6:0] DIM    = 7'b1000000;
   localparam logic [6:0] INVIS  = 7'b0100000;
   localparam logic [6:0] REV    = 7'b0010000;
   localparam logic [6:0] CURS   = 7'b0001000;
   localparam logic [6:0] WIDE   = 7'b0000100;
   localparam logic [6:0] UNDER  = 7'b0000010;
   localparam logic [6:0] STRIKE = 7'b0000001;
   localparam logic [6:0] PLAIN  = 7'b0000000;

   typedef struct packed {
      logic [15:0] fore;
      logic [15:0] back;
      logic        dim;
      logic        invisible;
      logic        reverse;
      logic        cursor;
      logic        wide_tail;
      logic        underline;
      logic        strike;
      logic [7:0]  bits;
      logic [3:0]  row;
   } cell_row_type;

   typedef struct packed {
      logic [15:0] colour;
      logic        last;
   } pixel_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [grpr_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [grpr_pkg::CSR_DATA_W-1:0] csr_wdata;

   grpr_req_if req_if ();
   grpr_rsp_if rsp_if ();

   glyph_row_pixel_rasterizer DUT (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   cell_row_type row_backlog[$];
   pixel_type    pixel_due[$];

   logic [grpr_pkg::SCALE_W-1:0] scale_reg = 2'd1;
   logic                         rev_reg   = 1'b0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int errors = 0;
   int rows_taken = 0;
   int pixels_seen = 0;
   int cycles = 0;
   int hold_left = 0;
   logic hold_toggle = 1'b0;
   logic hold_seen = 1'b0;

   always #HALF_PERIOD clock = ~clock;

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = grpr_pkg::CSR_PIXEL_SCALE;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.fore_colour = '0;
      req_if.back_colour = '0;
      req_if.dim_flag = 1'b0;
      req_if.invisible_flag = 1'b0;
      req_if.reverse_flag = 1'b0;
      req_if.cursor_here = 1'b0;
      req_if.wide_tail_flag = 1'b0;
      req_if.underline_flag = 1'b0;
      req_if.strike_flag = 1'b0;
      req_if.glyph_bits = '0;
      req_if.glyph_row = '0;
      rsp_if.ready = 1'b0;
   end

   function automatic logic [15:0] dim_colour(logic [15:0] c);
      logic [15:0] v;
      v = {c[7:0], c[15:8]};
      v = {1'b0, v[15:12], 1'b0, v[10:6], 1'b0, v[4:1]};
      return {v[7:0], v[15:8]};
   endfunction

   // Expand one cell row into the pixels it must produce, in raster order.
   function automatic void raster_row(cell_row_type r);
      logic [15:0] fg, bg, tmp;
      logic [7:0]  bits;
      int mag, total, n;
      pixel_type p;
      fg = r.fore;
      bg = r.back;
      if (r.dim) fg = dim_colour(fg);
      if (r.invisible) fg = bg;
      if (r.reverse ^ rev_reg ^ r.cursor) begin
         tmp = fg;
         fg = bg;
         bg = tmp;
      end
      bits = r.wide_tail ? 8'h00 : r.bits;
      if (r.underline && r.row == grpr_pkg::UNDERLINE_ROW) bits = grpr_pkg::BAR_BITS;
      if (r.strike && r.row == grpr_pkg::STRIKE_ROW) bits = grpr_pkg::BAR_BITS;
      mag = (scale_reg == 0) ? 1 : int'(scale_reg);
      if (mag > grpr_pkg::MAX_MAGNIFY_DEF) mag = grpr_pkg::MAX_MAGNIFY_DEF;
      total = grpr_pkg::CELL_WIDTH_DEF * mag * mag;
      n = 0;
      for (int sy = 0; sy < mag; sy++) begin
         for (int gx = 0; gx < grpr_pkg::CELL_WIDTH_DEF; gx++) begin
            for (int sx = 0; sx < mag; sx++) begin
               p.colour = bits[7 - gx] ? fg : bg;
               p.last = (n == total - 1);
               pixel_due.push_back(p);
               n++;
            end
         end
      end
   endfunction

   function automatic cell_row_type mk_row(logic [15:0] fore, logic [15:0] back,
                                           logic [6:0] attrs, logic [7:0] bits,
                                           logic [3:0] row);
      return {fore, back, attrs, bits, row};
   endfunction

   function automatic cell_row_type random_row();
      cell_row_type r;
      r.fore = ($urandom_range(7) == 0) ? {16{$urandom_range(1) == 1}} : 16'($urandom);
      r.back = ($urandom_range(7) == 0) ? {16{$urandom_range(1) == 1}} : 16'($urandom);
      r.dim = 1'($urandom_range(1));
      r.invisible = ($urandom_range(3) == 0);
      r.reverse = 1'($urandom_range(1));
      r.cursor = ($urandom_range(3) == 0);
      r.wide_tail = ($urandom_range(3) == 0);
      r.underline = 1'($urandom_range(1));
      r.strike = 1'($urandom_range(1));
      r.bits = 8'($urandom);
      // favor the bar rows so underline and strike actually show
      if ($urandom_range(2) == 0)
         r.row = $urandom_range(1) ? grpr_pkg::STRIKE_ROW : grpr_pkg::UNDERLINE_ROW;
      else
         r.row = 4'($urandom_range(15));
      return r;
   endfunction

   // Sender: hold the offered item until taken, then advance the backlog.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!(req_if.valid && !req_if.ready)) begin
         if (req_if.valid) begin
            raster_row(row_backlog[0]);
            void'(row_backlog.pop_front());
            rows_taken++;
         end
         if (row_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_if.valid <= 1'b1;
            req_if.fore_colour <= row_backlog[0].fore;
            req_if.back_colour <= row_backlog[0].back;
            req_if.dim_flag <= row_backlog[0].dim;
            req_if.invisible_flag <= row_backlog[0].invisible;
            req_if.reverse_flag <= row_backlog[0].reverse;
            req_if.cursor_here <= row_backlog[0].cursor;
            req_if.wide_tail_flag <= row_backlog[0].wide_tail;
            req_if.underline_flag <= row_backlog[0].underline;
            req_if.strike_flag <= row_backlog[0].strike;
            req_if.glyph_bits <= row_backlog[0].bits;
            req_if.glyph_row <= row_backlog[0].row;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Receiver: random backpressure, plus a long hold-off whenever the toggle flips.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_if.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= LONG_HOLD;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : pixel_check
      pixel_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         pixels_seen++;
         if (pixel_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: pixel with nothing pending: colour %h last %b", $realtime,
                        rsp_if.pixel_colour, rsp_if.last_pixel);
         end else begin
            want = pixel_due.pop_front();
            if (rsp_if.pixel_colour !== want.colour || rsp_if.last_pixel !== want.last) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: pixel mismatch: expected colour %h last %b, got %h last %b",
                           $realtime, want.colour, want.last, rsp_if.pixel_colour,
                           rsp_if.last_pixel);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d pixels still pending", cycles,
                  pixel_due.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic write_csr(input logic [grpr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [grpr_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == grpr_pkg::CSR_PIXEL_SCALE)
         scale_reg = val;
      else
         rev_reg = val[0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_mode(input logic [1:0] scale, input logic grev);
      write_csr(grpr_pkg::CSR_PIXEL_SCALE, scale);
      write_csr(grpr_pkg::CSR_GLOBAL_REVERSE, {1'b0, grev});
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (row_backlog.size() != 0 || req_if.valid || pixel_due.size() != 0);
   endtask

   task automatic queue_random(input int count);
      @(negedge clock);
      repeat (count) row_backlog.push_back(random_row());
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 11;
      recv_idle_pct = 71;
      set_mode(2'd1, 1'b0);
      @(negedge clock);
      row_backlog.push_back(mk_row(16'hFFFF, 16'h0000, PLAIN, 8'hFF, 4'd0));
      row_backlog.push_back(mk_row(16'h0000, 16'hFFFF, PLAIN, 8'h00, 4'd0));
      row_backlog.push_back(mk_row(16'hA55A, 16'h5AA5, PLAIN, 8'hA8, 4'd3));
      row_backlog.push_back(mk_row(16'hFFFF, 16'h1234, DIM, 8'hFC, 4'd1));
      row_backlog.push_back(mk_row(16'h2108, 16'h0000, DIM, 8'h54, 4'd2));
      row_backlog.push_back(mk_row(16'hF800, 16'h07E0, INVIS, 8'hFC, 4'd4));
      row_backlog.push_back(mk_row(16'hFFFF, 16'h001F, DIM | INVIS, 8'hCC, 4'd5));
      row_backlog.push_back(mk_row(16'h1F00, 16'hE007, REV, 8'hE0, 4'd7));
      row_backlog.push_back(mk_row(16'h1F00, 16'hE007, CURS, 8'hE0, 4'd8));
      row_backlog.push_back(mk_row(16'h1F00, 16'hE007, REV | CURS, 8'hE0, 4'd9));
      row_backlog.push_back(mk_row(16'hFFFF, 16'h0000, WIDE, 8'hFF, 4'd10));
      row_backlog.push_back(mk_row(16'hFFFF, 16'h0000, UNDER, 8'h00,
                                   grpr_pkg::UNDERLINE_ROW));
      row_backlog.push_back(mk_row(16'hFFFF, 16'h0000, UNDER, 8'h00, 4'd10));
      row_backlog.push_back(mk_row(16'hFFFF, 16'h0000, STRIKE, 8'h00, grpr_pkg::STRIKE_ROW));
      row_backlog.push_back(mk_row(16'hFFFF, 16'h0000, STRIKE, 8'h24,
                                   grpr_pkg::UNDERLINE_ROW));
      row_backlog.push_back(mk_row(16'hFFFF, 16'h0000, UNDER | STRIKE, 8'h00,
                                   grpr_pkg::STRIKE_ROW));
      row_backlog.push_back(mk_row(16'hFFFF, 16'h0000, UNDER | STRIKE, 8'h00,
                                   grpr_pkg::UNDERLINE_ROW));
      row_backlog.push_back(mk_row(16'hFFFF, 16'h0000, UNDER | STRIKE, 8'h48, 4'd3));
      row_backlog.push_back(mk_row(16'h0F0F, 16'hF0F0, WIDE | UNDER, 8'hFF,
                                   grpr_pkg::UNDERLINE_ROW));
      row_backlog.push_back(mk_row(16'h0F0F, 16'hF0F0, WIDE | STRIKE, 8'hFF,
                                   grpr_pkg::STRIKE_ROW));
      row_backlog.push_back(mk_row(16'hFFFF, 16'h0000, UNDER | STRIKE, 8'h5C, 4'd12));
      row_backlog.push_back(mk_row(16'hFFFF, 16'h0000, UNDER | STRIKE, 8'hB4, 4'd15));
      row_backlog.push_back(mk_row(16'hFFFF, 16'h0000, PLAIN, 8'h03, 4'd2));
      row_backlog.push_back(mk_row(16'hFFFF, 16'hFFFF, 7'h7F, 8'hFF, 4'd15));
      wait_drained();

      set_mode(2'd2, 1'b1);
      queue_random(90);
      wait_drained();

      send_idle_pct = 71;
      recv_idle_pct = 11;
      // scale codes 0 and 3 lie outside the magnification range and clamp
      set_mode(2'd0, 1'b0);
      queue_random(70);
      wait_drained();
      set_mode(2'd3, 1'b1);
      queue_random(70);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_mode(2'd2, 1'b0);
      // stall the pixel side for a long stretch while rows keep coming
      @(posedge clock);
      hold_toggle <= ~hold_toggle;
      queue_random(90);
      wait_drained();

      set_mode(2'd1, 1'b1);
      queue_random(40);
      wait_drained();
      queue_random(40);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (pixel_due.size() != 0) begin
         errors++;
         $display("%0d expected pixels never arrived", pixel_due.size());
      end

      $display("Run covered %0d cell rows and %0d pixels over scale codes 0..3,", rows_taken,
               pixels_seen);
      $display("reverse video on and off, all attributes, bar rows and rows past the cell.");
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", errors);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
